// File: hdl/vertex_normal_accumulator_top_defines.svh
// Assertion macros for the vertex normal accumulator
`ifndef VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH
`define VERTEX_NORMAL_ACCUMULATOR_TOP_DEFINES_SVH

// Implication checked on every rising clock edge outside reset
`define VNA_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// Next-cycle implication checked outside reset
`define VNA_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: hdl/vna_pkg.sv
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, constants and command codes of the vertex normal accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
package vna_pkg;

    localparam int SlotW = 8;
    localparam int Depth = 256;
    localparam int SumW  = 48;
    localparam int PosW  = 16;
    localparam int ThrW  = 40;
    localparam logic [ThrW-1:0] THRESH_RESET = 40'd549755814;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_STORE = 2'd1,
        CMD_FACE  = 2'd2,
        CMD_READ  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [SlotW-1:0]  slot;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
        logic [SlotW-1:0]  corner_a;
        logic [SlotW-1:0]  corner_b;
        logic [SlotW-1:0]  corner_c;
    } item_t;

    typedef struct packed {
        logic              status;
        logic [SlotW-1:0]  face_a;
        logic [SlotW-1:0]  face_b;
        logic [SlotW-1:0]  face_c;
        logic              was_swapped;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
    } result_t;

endpackage
`default_nettype wire

// File: hdl/vna_queue.sv
// ----------------------------------------------------------------------------
// vna_queue
// Two-entry item queue between the front part and the execution engine.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_queue
    import vna_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output item_t      out_item
);
    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: hdl/vna_engine.sv
// ----------------------------------------------------------------------------
// vna_engine
// Sequencer that executes one command: vertex store, sum clear through valid
// bits, face winding test and sum update, normalized read with serial sqrt and divide.
// ----------------------------------------------------------------------------
`default_nettype none
module vna_engine
    import vna_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [ThrW-1:0] threshold,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire item_t           in_item,
    output logic                 res_valid,
    input  wire logic            res_ready,
    output result_t              res
);
    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_FRD_A, S_FRD_B, S_FRD_C, S_FCAP, S_DET1, S_DET2,
        S_DET3, S_CRS1, S_CRS2, S_UPD_RD, S_UPD_WAIT, S_UPD_WR,
        S_RD_RD, S_RD_WAIT, S_RD_MAG, S_RD_NORM, S_RD_SQ1, S_RD_SQ2,
        S_SQRT, S_DIV_INIT, S_DIV, S_OUT
    } state_t;

    state_t state_reg;

    // Memories
    logic [3*PosW-1:0]  pos_mem [Depth];
    logic [3*SumW-1:0]  sum_mem [Depth];
    logic [Depth-1:0]   sum_valid_reg;
    logic [3*PosW-1:0]  pos_rd_reg;
    logic [3*SumW-1:0]  sum_rd_reg;
    logic               sum_rd_ok_reg;
    logic [SlotW-1:0]   pos_addr, sum_raddr_reg;

    item_t              it_reg;
    logic signed [PosW-1:0] ax_reg, ay_reg, az_reg, bx_reg, by_reg, bz_reg;
    logic signed [PosW-1:0] cx_reg, cy_reg, cz_reg;
    logic signed [33:0] p0_reg, p1_reg, p2_reg;
    logic signed [51:0] det_reg;
    logic signed [PosW:0] ux_reg, uy_reg, uz_reg, vx_reg, vy_reg, vz_reg;
    logic signed [34:0] n0_reg, n1_reg, n2_reg;
    logic [SlotW-1:0]   fb_reg, fc_reg;
    logic               sw_reg;
    logic [1:0]         k_reg;

    logic signed [SumW-1:0] s0_reg, s1_reg, s2_reg;
    logic [SumW-1:0]    m0_reg, m1_reg, m2_reg;
    logic [5:0]         p_reg;
    logic [30:0]        q0_reg, q1_reg, q2_reg;
    logic [61:0]        sq0_reg, sq1_reg, sq2_reg;
    logic [63:0]        rad_reg, root_reg, bit_reg;
    logic [1:0]         dj_reg;
    logic [45:0]        num_reg;
    logic [46:0]        rem_reg;
    logic [45:0]        quo_reg;
    logic [5:0]         dcnt_reg;
    logic [15:0]        nq0_reg, nq1_reg;
    result_t            res_reg;
    result_t            out_reg;
    logic               res_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = out_reg;

    // Saturating add of a face normal component to a stored sum
    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                                input logic signed [34:0] d);
        logic signed [SumW:0] r;
        begin
            r = $signed({s[SumW-1], s}) + (SumW+1)'(d);
            if (r[SumW] != r[SumW-1])
                sat_add = r[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
            else
                sat_add = r[SumW-1:0];
        end
    endfunction

    function automatic logic [SumW-1:0] magn(input logic [SumW-1:0] v);
        magn = v[SumW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [5:0] msb_pos(input logic [SumW-1:0] v);
        logic [5:0] p;
        begin
            p = 6'd0;
            for (int i = 0; i < SumW; i++)
                if (v[i]) p = 6'(i);
            msb_pos = p;
        end
    endfunction

    function automatic logic [30:0] norm_one(input logic [SumW-1:0] m,
                                             input logic [5:0] p);
        logic [SumW+30:0] w;
        begin
            w = {31'd0, m};
            if (p > 6'd30) w = w >> (p - 6'd30);
            else w = w << (6'd30 - p);
            norm_one = w[30:0];
        end
    endfunction

    function automatic logic [15:0] apply_sign(input logic [15:0] q, input logic neg);
        apply_sign = neg ? (~q + 1'b1) : q;
    endfunction

    always_comb
    begin
        unique case (state_reg)
            S_FRD_A: pos_addr = it_reg.corner_a;
            S_FRD_B: pos_addr = it_reg.corner_b;
            default: pos_addr = it_reg.corner_c;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid && in_ready && in_item.command == CMD_STORE)
            pos_mem[in_item.slot] <= {in_item.pos_x, in_item.pos_y, in_item.pos_z};
        pos_rd_reg <= pos_mem[pos_addr];
        sum_rd_reg <= sum_mem[sum_raddr_reg];
        if (state_reg == S_UPD_WR)
            sum_mem[sum_raddr_reg] <= {sat_add(sum_rd_ok_reg ? sum_rd_reg[143:96] : '0, n0_reg),
                                       sat_add(sum_rd_ok_reg ? sum_rd_reg[95:48] : '0, n1_reg),
                                       sat_add(sum_rd_ok_reg ? sum_rd_reg[47:0] : '0, n2_reg)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            sum_valid_reg <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready) res_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        it_reg  <= in_item;
                        res_reg <= '0;
                        unique case (in_item.command)
                            CMD_CLEAR: state_reg <= S_CLR;
                            CMD_STORE: state_reg <= S_OUT;
                            CMD_FACE:  state_reg <= S_FRD_A;
                            CMD_READ:
                            begin
                                sum_raddr_reg <= in_item.slot;
                                state_reg     <= S_RD_RD;
                            end
                            default:   state_reg <= S_OUT;
                        endcase
                    end
                end
                S_CLR:
                begin
                    sum_valid_reg <= '0;
                    state_reg     <= S_OUT;
                end
                S_FRD_A: state_reg <= S_FRD_B;
                S_FRD_B:
                begin
                    {ax_reg, ay_reg, az_reg} <= pos_rd_reg;
                    state_reg <= S_FRD_C;
                end
                S_FRD_C:
                begin
                    {bx_reg, by_reg, bz_reg} <= pos_rd_reg;
                    state_reg <= S_FCAP;
                end
                S_FCAP:
                begin
                    {cx_reg, cy_reg, cz_reg} <= pos_rd_reg;
                    state_reg <= S_DET1;
                end
                S_DET1:
                begin
                    p0_reg <= 34'(by_reg * cz_reg) - 34'(bz_reg * cy_reg);
                    p1_reg <= 34'(bz_reg * cx_reg) - 34'(bx_reg * cz_reg);
                    p2_reg <= 34'(bx_reg * cy_reg) - 34'(by_reg * cx_reg);
                    state_reg <= S_DET2;
                end
                S_DET2:
                begin
                    det_reg <= 52'(ax_reg * p0_reg) + 52'(ay_reg * p1_reg)
                             + 52'(az_reg * p2_reg);
                    state_reg <= S_DET3;
                end
                S_DET3:
                begin
                    sw_reg <= (det_reg > $signed({12'd0, threshold}));
                    if (det_reg > $signed({12'd0, threshold}))
                    begin
                        fb_reg <= it_reg.corner_c;
                        fc_reg <= it_reg.corner_b;
                        ux_reg <= 17'(cx_reg) - 17'(ax_reg);
                        uy_reg <= 17'(cy_reg) - 17'(ay_reg);
                        uz_reg <= 17'(cz_reg) - 17'(az_reg);
                        vx_reg <= 17'(bx_reg) - 17'(ax_reg);
                        vy_reg <= 17'(by_reg) - 17'(ay_reg);
                        vz_reg <= 17'(bz_reg) - 17'(az_reg);
                    end
                    else
                    begin
                        fb_reg <= it_reg.corner_b;
                        fc_reg <= it_reg.corner_c;
                        ux_reg <= 17'(bx_reg) - 17'(ax_reg);
                        uy_reg <= 17'(by_reg) - 17'(ay_reg);
                        uz_reg <= 17'(bz_reg) - 17'(az_reg);
                        vx_reg <= 17'(cx_reg) - 17'(ax_reg);
                        vy_reg <= 17'(cy_reg) - 17'(ay_reg);
                        vz_reg <= 17'(cz_reg) - 17'(az_reg);
                    end
                    state_reg <= S_CRS1;
                end
                S_CRS1:
                begin
                    n0_reg <= 35'(uy_reg * vz_reg) - 35'(uz_reg * vy_reg);
                    n1_reg <= 35'(uz_reg * vx_reg) - 35'(ux_reg * vz_reg);
                    n2_reg <= 35'(ux_reg * vy_reg) - 35'(uy_reg * vx_reg);
                    k_reg  <= 2'd0;
                    state_reg <= S_CRS2;
                end
                S_CRS2:
                begin
                    sum_raddr_reg <= it_reg.corner_a;
                    state_reg     <= S_UPD_RD;
                end
                S_UPD_RD: state_reg <= S_UPD_WAIT;
                S_UPD_WAIT:
                begin
                    sum_rd_ok_reg <= sum_valid_reg[sum_raddr_reg];
                    state_reg     <= S_UPD_WR;
                end
                S_UPD_WR:
                begin
                    sum_valid_reg[sum_raddr_reg] <= 1'b1;
                    if (k_reg == 2'd2)
                    begin
                        res_reg.face_a      <= it_reg.corner_a;
                        res_reg.face_b      <= fb_reg;
                        res_reg.face_c      <= fc_reg;
                        res_reg.was_swapped <= sw_reg;
                        state_reg           <= S_OUT;
                    end
                    else
                    begin
                        k_reg         <= k_reg + 2'd1;
                        sum_raddr_reg <= (k_reg == 2'd0) ? fb_reg : fc_reg;
                        state_reg     <= S_UPD_RD;
                    end
                end
                S_RD_RD: state_reg <= S_RD_WAIT;
                S_RD_WAIT:
                begin
                    if (sum_valid_reg[sum_raddr_reg])
                        {s0_reg, s1_reg, s2_reg} <= sum_rd_reg;
                    else
                        {s0_reg, s1_reg, s2_reg} <= '0;
                    state_reg <= S_RD_MAG;
                end
                S_RD_MAG:
                begin
                    m0_reg <= magn(s0_reg);
                    m1_reg <= magn(s1_reg);
                    m2_reg <= magn(s2_reg);
                    p_reg  <= msb_pos(magn(s0_reg) | magn(s1_reg) | magn(s2_reg));
                    if ((s0_reg | s1_reg | s2_reg) == '0)
                    begin
                        res_reg.status <= 1'b1;
                        state_reg      <= S_OUT;
                    end
                    else
                        state_reg <= S_RD_NORM;
                end
                S_RD_NORM:
                begin
                    q0_reg <= norm_one(m0_reg, p_reg);
                    q1_reg <= norm_one(m1_reg, p_reg);
                    q2_reg <= norm_one(m2_reg, p_reg);
                    state_reg <= S_RD_SQ1;
                end
                S_RD_SQ1:
                begin
                    sq0_reg <= q0_reg * q0_reg;
                    sq1_reg <= q1_reg * q1_reg;
                    sq2_reg <= q2_reg * q2_reg;
                    state_reg <= S_RD_SQ2;
                end
                S_RD_SQ2:
                begin
                    rad_reg  <= 64'(sq0_reg) + 64'(sq1_reg) + 64'(sq2_reg);
                    root_reg <= '0;
                    bit_reg  <= 64'd1 << 62;
                    state_reg <= S_SQRT;
                end
                S_SQRT:
                begin
                    if (bit_reg == '0)
                    begin
                        dj_reg    <= 2'd0;
                        state_reg <= S_DIV_INIT;
                    end
                    else
                    begin
                        if (rad_reg >= root_reg + bit_reg)
                        begin
                            rad_reg  <= rad_reg - (root_reg + bit_reg);
                            root_reg <= (root_reg >> 1) + bit_reg;
                        end
                        else
                            root_reg <= root_reg >> 1;
                        bit_reg <= bit_reg >> 2;
                    end
                end
                S_DIV_INIT:
                begin
                    unique case (dj_reg)
                        2'd0:    num_reg <= {q0_reg, 14'd0} + 46'(root_reg[32:1]);
                        2'd1:    num_reg <= {q1_reg, 14'd0} + 46'(root_reg[32:1]);
                        default: num_reg <= {q2_reg, 14'd0} + 46'(root_reg[32:1]);
                    endcase
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    dcnt_reg  <= 6'd46;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (dcnt_reg == 6'd0)
                    begin
                        unique case (dj_reg)
                            2'd0: nq0_reg <= quo_reg[15:0];
                            2'd1: nq1_reg <= quo_reg[15:0];
                            default: ;
                        endcase
                        if (dj_reg == 2'd2)
                        begin
                            res_reg.normal_x <= apply_sign(nq0_reg, s0_reg[SumW-1]);
                            res_reg.normal_y <= apply_sign(nq1_reg, s1_reg[SumW-1]);
                            res_reg.normal_z <= apply_sign(quo_reg[15:0], s2_reg[SumW-1]);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            dj_reg    <= dj_reg + 2'd1;
                            state_reg <= S_DIV_INIT;
                        end
                    end
                    else
                    begin
                        if ({rem_reg[45:0], num_reg[45]} >= 47'(root_reg[32:0]))
                        begin
                            rem_reg <= {rem_reg[45:0], num_reg[45]} - 47'(root_reg[32:0]);
                            quo_reg <= {quo_reg[44:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= {rem_reg[45:0], num_reg[45]};
                            quo_reg <= {quo_reg[44:0], 1'b0};
                        end
                        num_reg  <= {num_reg[44:0], 1'b0};
                        dcnt_reg <= dcnt_reg - 6'd1;
                    end
                end
                S_OUT:
                begin
                    if (!res_valid_reg || res_ready)
                    begin
                        out_reg       <= res_reg;
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: hdl/vertex_normal_accumulator_top.sv
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Vertex table with area-weighted normal sums, face winding fix and
// normalized read-back.
//
// Input stream s_axis carries one command beat; output stream m_axis returns
// exactly one result beat per command. cfg writes winding_threshold.
// A command enters a two-entry queue, then the sequencer runs it. A face
// command does three position reads, a triple product, a cross product and
// three read-modify-write sum updates on one memory port; a read does a
// serial square root plus three serial divides. The sequencer takes the next
// command in the cycle after it loads a result.
// Reset clears the threshold to its default and marks all sums zero through
// per-slot valid bits, no sweep. When m_axis stalls, the finished result
// holds in the output register, the sequencer holds its next result until
// that register frees, and the queue keeps taking up to two beats.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vertex_normal_accumulator_top_defines.svh"
module vertex_normal_accumulator_top
    import vna_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [39:0] cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[1:0], slot[9:2], pos_x[25:10], pos_y[41:26], pos_z[57:42],
    // corner_a[65:58], corner_b[73:66], corner_c[81:74], zero pad to 88
    input  wire logic [87:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[0], face_a[8:1], face_b[16:9], face_c[24:17], was_swapped[25],
    // normal_x[41:26], normal_y[57:42], normal_z[73:58], zero pad to 80
    output logic [79:0]      m_axis_tdata
);
    logic [ThrW-1:0] thr_reg;
    item_t   in_item, q_item;
    logic    q_valid, q_ready;
    result_t r;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) thr_reg <= THRESH_RESET;
        else if (cfg_valid) thr_reg <= cfg_data;
    end

    always_comb
    begin
        in_item.command  = cmd_t'(s_axis_tdata[1:0]);
        in_item.slot     = s_axis_tdata[9:2];
        in_item.pos_x    = s_axis_tdata[25:10];
        in_item.pos_y    = s_axis_tdata[41:26];
        in_item.pos_z    = s_axis_tdata[57:42];
        in_item.corner_a = s_axis_tdata[65:58];
        in_item.corner_b = s_axis_tdata[73:66];
        in_item.corner_c = s_axis_tdata[81:74];
    end

    vna_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    vna_engine u_engine (
        .clk(clk), .rst_n(rst_n), .threshold(thr_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tdata = {6'd0, r.normal_z, r.normal_y, r.normal_x, r.was_swapped,
                           r.face_c, r.face_b, r.face_a, r.status};

    `VNA_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
    `VNA_ASSERT_IMPLY(a_status_zero, clk, rst_n, m_axis_tvalid && r.status,
        r.normal_x == 16'd0 && r.normal_y == 16'd0 && r.normal_z == 16'd0,
        "zero-sum read carries a nonzero normal")
endmodule
`default_nettype wire
